// ===== hw/rtl/srls_pkg.sv =====
`timescale 1ns / 1ps
// Package for the row store line splitter: widths, constants and the
// segment record passed from the front end to the beat emitter. No dependencies.
package srls_pkg;

    localparam int ADDR_W        = 48;
    localparam int ROWB_W        = 10;
    localparam int DATA_W        = 64;
    localparam int FILL_W        = 7;
    localparam int MAX_LINE_BYTES = 64;
    localparam int MAX_ROW_BYTES = 512;
    localparam int SEG_BEATS     = MAX_LINE_BYTES / 8;
    localparam int BEAT_W        = $clog2(SEG_BEATS);
    localparam int LG_W          = 3;
    localparam int S_TDATA_W     = 128;
    localparam int M_TDATA_W     = 128;

    localparam logic [LG_W-1:0] LINE_LG_MIN   = 3'd3;
    localparam logic [LG_W-1:0] LINE_LG_MAX   = 3'd6;
    localparam logic [LG_W-1:0] LINE_LG_RESET = 3'd6;

    typedef enum logic
    {
        REQ_START = 1'b0,
        REQ_ELEM  = 1'b1
    } req_type_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0]            addr;
        logic [FILL_W-1:0]            bytes;
        logic                         done;
        logic [MAX_LINE_BYTES*8-1:0]  data;
    } seg_t;

endpackage

// ===== hw/rtl/srls_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts start and element items, tracks the row and packs
// elements into the open line segment. Uses srls_pkg.
module srls_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [srls_pkg::LG_W-1:0]     line_lg,
    input  logic                          item_valid,
    input  srls_pkg::req_type_t           req_type,
    input  logic [srls_pkg::ADDR_W-1:0]   start_addr,
    input  logic [srls_pkg::ROWB_W-1:0]   row_bytes,
    input  logic [1:0]                    elem_size_code,
    input  logic [srls_pkg::DATA_W-1:0]   elem_data,
    output logic                          push,
    output srls_pkg::seg_t                push_seg
);
    import srls_pkg::*;

    logic [MAX_LINE_BYTES*8-1:0] buf_reg, buf_next;
    logic [FILL_W-1:0]           fill_reg, fill_next;
    logic [ADDR_W-1:0]           naddr_reg, naddr_next;
    logic [ADDR_W-1:0]           seg_addr_reg, seg_addr_next;
    logic [ROWB_W-1:0]           rem_reg, rem_next;
    logic [1:0]                  esc_reg, esc_next;
    logic                        active_reg, active_next;

    logic [LG_W-1:0]             lg;
    logic [5:0]                  line_mask;
    logic [FILL_W-1:0]           esize;
    logic [FILL_W-1:0]           new_fill;
    logic [ADDR_W-1:0]           new_addr;
    logic [ROWB_W-1:0]           rem_dec;
    logic                        done;
    logic                        close;
    logic [ROWB_W-1:0]           rb_sat;
    logic [ADDR_W-1:0]           st_mask;
    logic [ADDR_W-1:0]           st_addr;
    logic [ROWB_W-1:0]           st_elems;
    logic [5:0]                  rel;

    always_comb
    begin
        lg = line_lg;
        if (lg < LINE_LG_MIN)
            lg = LINE_LG_MIN;
        if (lg > LINE_LG_MAX)
            lg = LINE_LG_MAX;
        line_mask = 6'((7'd1 << lg) - 7'd1);
    end

    assign esize    = FILL_W'(1) << esc_reg;
    assign new_fill = fill_reg + esize;
    assign new_addr = naddr_reg + ADDR_W'(esize);
    assign rem_dec  = rem_reg - ROWB_W'(1);
    assign done     = (rem_dec == '0);
    assign close    = done || ((new_addr[5:0] & line_mask) == 6'd0);

    assign rb_sat   = (row_bytes > ROWB_W'(MAX_ROW_BYTES)) ? ROWB_W'(MAX_ROW_BYTES) : row_bytes;
    assign st_mask  = ~((ADDR_W'(1) << elem_size_code) - ADDR_W'(1));
    assign st_addr  = start_addr & st_mask;
    assign st_elems = rb_sat >> elem_size_code;

    // merge the element bytes into the open segment
    always_comb
    begin
        buf_next = buf_reg;
        rel      = '0;
        for (int j = 0; j < MAX_LINE_BYTES; j++)
        begin
            rel = 6'(j) - fill_reg[5:0];
            if ((FILL_W'(j) >= fill_reg) && (FILL_W'(j) < new_fill))
                buf_next[j*8 +: 8] = elem_data[rel[2:0]*8 +: 8];
        end
    end

    always_comb
    begin
        fill_next     = fill_reg;
        naddr_next    = naddr_reg;
        seg_addr_next = seg_addr_reg;
        rem_next      = rem_reg;
        esc_next      = esc_reg;
        active_next   = active_reg;
        push          = 1'b0;
        if (item_valid)
        begin
            if (req_type == REQ_START)
            begin
                esc_next      = elem_size_code;
                rem_next      = st_elems;
                naddr_next    = st_addr;
                seg_addr_next = st_addr;
                fill_next     = '0;
                active_next   = (st_elems != '0);
            end
            else if (active_reg)
            begin
                naddr_next = new_addr;
                rem_next   = rem_dec;
                fill_next  = new_fill;
                if (close)
                begin
                    push          = 1'b1;
                    fill_next     = '0;
                    seg_addr_next = new_addr;
                    if (done)
                        active_next = 1'b0;
                end
            end
        end
    end

    assign push_seg.addr  = seg_addr_reg;
    assign push_seg.bytes = new_fill;
    assign push_seg.done  = done;
    assign push_seg.data  = buf_next;

    always_ff @(posedge clk)
    begin
        if (item_valid && (req_type == REQ_ELEM) && active_reg)
            buf_reg <= buf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            naddr_reg    <= '0;
            seg_addr_reg <= '0;
            rem_reg      <= '0;
            esc_reg      <= '0;
            active_reg   <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            naddr_reg    <= naddr_next;
            seg_addr_reg <= seg_addr_next;
            rem_reg      <= rem_next;
            esc_reg      <= esc_next;
            active_reg   <= active_next;
        end
    end

endmodule

// ===== hw/rtl/srls_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of closed segments between front end and beat emitter.
// Uses srls_pkg.
module srls_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  srls_pkg::seg_t push_seg,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output srls_pkg::seg_t head
);
    import srls_pkg::*;

    seg_t        mem_reg [2];
    logic        wr_reg, wr_next;
    logic        rd_reg, rd_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_seg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/srls_back.sv =====
`timescale 1ns / 1ps
// Beat emitter: sends the segment at the queue head as 64-bit beats and
// pops it after the last beat. Uses srls_pkg.
module srls_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          empty,
    input  srls_pkg::seg_t                head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [srls_pkg::ADDR_W-1:0]   write_addr,
    output logic [srls_pkg::FILL_W-1:0]   write_bytes,
    output logic [srls_pkg::DATA_W-1:0]   beat_data,
    output logic [srls_pkg::BEAT_W-1:0]   beat_index,
    output logic                          beat_last,
    output logic                          row_done
);
    import srls_pkg::*;

    logic [BEAT_W-1:0] idx_reg, idx_next;
    logic [FILL_W-1:0] last_idx;
    logic [DATA_W-1:0] raw;
    logic [5:0]        pos;

    assign last_idx = (head.bytes - FILL_W'(1)) >> 3;
    assign raw      = head.data[idx_reg*DATA_W +: DATA_W];

    // bytes beyond the segment end read as zero
    always_comb
    begin
        beat_data = '0;
        pos       = '0;
        for (int b = 0; b < 8; b++)
        begin
            pos = {idx_reg, 3'(b)};
            if ({1'b0, pos} < head.bytes)
                beat_data[b*8 +: 8] = raw[b*8 +: 8];
        end
    end

    assign out_valid   = !empty;
    assign write_addr  = head.addr;
    assign write_bytes = head.bytes;
    assign beat_index  = idx_reg;
    assign beat_last   = (idx_reg == last_idx[BEAT_W-1:0]);
    assign row_done    = head.done;
    assign pop         = out_valid && out_ready && beat_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (out_valid && out_ready)
            idx_next = beat_last ? '0 : idx_reg + BEAT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule

// ===== hw/rtl/store_row_line_splitter_core.sv =====
`timescale 1ns / 1ps
// Top level of the row store line splitter: configuration register, front
// end, segment queue and beat emitter. Uses srls_pkg, srls_front, srls_queue, srls_back.
//
// An item is taken in the cycle it is offered while the two-entry segment
// queue has room, so the block sustains one item per clock. A closed segment
// of N bytes leaves as ceil(N/8) beats from the queue head, one per clock while m_tready
// is high; since a segment never has more beats than the elements that filled it, the
// beat emitter keeps pace with the input. Start items and elements that do not close a
// segment produce no output. A closing segment is registered in the queue before its
// first beat is offered. cfg_ready is always high; the user must write the line size
// register through cfg_valid/cfg_data only while the block is idle (not enforced here).
module store_row_line_splitter_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [srls_pkg::LG_W-1:0]       cfg_data,       // line_bytes_log2
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [47:0] start_addr, [57:48] row_bytes, [59:58] elem_size_code,
    // [123:60] elem_data, [127:124] zero
    input  logic [srls_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,        // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [47:0] write_addr, [54:48] write_bytes, [118:55] beat_data,
    // [121:119] beat_index, [127:122] zero
    output logic [srls_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast,        // beat_last
    output logic                            m_tuser         // row_done
);
    import srls_pkg::*;

    logic [LG_W-1:0]   line_lg_reg;
    logic              push;
    seg_t              push_seg;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    seg_t              head;
    logic [ADDR_W-1:0] write_addr;
    logic [FILL_W-1:0] write_bytes;
    logic [DATA_W-1:0] beat_data;
    logic [BEAT_W-1:0] beat_index;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_lg_reg <= LINE_LG_RESET;
        else if (cfg_valid)
            line_lg_reg <= cfg_data;
    end

    srls_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .line_lg        (line_lg_reg),
        .item_valid     (s_tvalid && s_tready),
        .req_type       (req_type_t'(s_tuser)),
        .start_addr     (s_tdata[47:0]),
        .row_bytes      (s_tdata[57:48]),
        .elem_size_code (s_tdata[59:58]),
        .elem_data      (s_tdata[123:60]),
        .push           (push),
        .push_seg       (push_seg)
    );

    srls_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_seg (push_seg),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    srls_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (q_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .write_addr  (write_addr),
        .write_bytes (write_bytes),
        .beat_data   (beat_data),
        .beat_index  (beat_index),
        .beat_last   (m_tlast),
        .row_done    (m_tuser)
    );

    assign m_tdata = {6'd0, beat_index, beat_data, write_bytes, write_addr};

endmodule
